[hdl/bphs_pkg.sv]
// bphs_pkg: shared types and constants of the button press/hold scanner
// no dependencies; imported by the interfaces, the button cell and the top level
`timescale 1ns / 1ps

package bphs_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned PIN_COUNT   = 4;
  localparam int unsigned BTN_IDX_W   = 2;
  localparam int unsigned EVENT_W     = 2;
  localparam int unsigned EVENTS_W    = 8;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_W-1:0] SCAN_INTERVAL_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_LIMIT_RST    = 16'd500;

  typedef enum logic [EVENT_W-1:0] {
    EV_IDLE    = 2'd0,
    EV_PRESSED = 2'd1,
    EV_HELD    = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_INTERVAL = 1'b0,
    CFG_HOLD_LIMIT    = 1'b1
  } cfg_idx_e;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // control shared by all button cells for the item in the input register
  typedef struct packed {
    logic              scan_en;
    logic              query_en;
    logic [TIME_W-1:0] now_ms;
    logic [CFG_W-1:0]  hold_limit;
  } cell_ctrl_t;

endpackage

[hdl/bphs_in_if.sv]
// bphs_in_if: input item channel, valid/ready plus sample/query payload
// depends on bphs_pkg for field widths
`timescale 1ns / 1ps

interface bphs_in_if
  import bphs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [TIME_W-1:0]    now_ms;
  logic [PIN_COUNT-1:0] pin_levels;
  logic [BTN_IDX_W-1:0] button_index;

  modport source (output valid, cmd, now_ms, pin_levels, button_index, input ready);
  modport sink   (input valid, cmd, now_ms, pin_levels, button_index, output ready);
endinterface

[hdl/bphs_out_if.sv]
// bphs_out_if: result item channel, valid/ready plus clicked/scanned/events
// depends on bphs_pkg for field widths
`timescale 1ns / 1ps

interface bphs_out_if
  import bphs_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                clicked;
  logic                scanned;
  logic [EVENTS_W-1:0] events;

  modport source (output valid, clicked, scanned, events, input ready);
  modport sink   (input valid, clicked, scanned, events, output ready);
endinterface

[hdl/bphs_cell.sv]
// bphs_cell: state and update logic of one button (level, press start, event)
// depends on bphs_pkg
`timescale 1ns / 1ps

module bphs_cell
  import bphs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       pressed_i,
  input  logic       sel_i,
  output event_e     event_next_o,
  output logic       clicked_o
);

  logic              prev_q, prev_d;
  logic [TIME_W-1:0] start_q, start_d;
  event_e            event_q, event_d;
  logic [TIME_W-1:0] held_for;

  assign held_for = ctrl_i.now_ms - start_q;

  always_comb begin
    prev_d  = prev_q;
    start_d = start_q;
    event_d = event_q;
    if (ctrl_i.scan_en) begin
      prev_d = pressed_i;
      if (pressed_i && !prev_q) begin
        event_d = EV_PRESSED;
        start_d = ctrl_i.now_ms;
      end else if (pressed_i && prev_q) begin
        if (held_for > TIME_W'(ctrl_i.hold_limit)) begin
          event_d = EV_HELD;
        end
      end else if (!pressed_i && prev_q) begin
        event_d = EV_IDLE;
      end
    end else if (ctrl_i.query_en && sel_i && event_q == EV_PRESSED) begin
      // reading a fresh press consumes it
      event_d = EV_IDLE;
    end
  end

  assign clicked_o    = sel_i && (event_q == EV_PRESSED || event_q == EV_HELD);
  assign event_next_o = event_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      event_q <= EV_IDLE;
    end else begin
      prev_q  <= prev_d;
      event_q <= event_d;
    end
  end

  // only read while prev_q is set, which a press edge wrote
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
  end

endmodule

[hdl/button_press_hold_scanner_unit.sv]
// button_press_hold_scanner_unit: top level, input register, scan gate, result register
// depends on bphs_pkg, bphs_in_if, bphs_out_if and bphs_cell
// path: an accepted item passes the input register and then the result register, where
// its result becomes valid; a result that is not taken stalls the item behind it
// throughput: one item per cycle; all buttons update in parallel in a single pass
// a stalled result register holds back the input register, which still fills once
// reset: async active low; clears valids, last scan time, levels and events; the
// registers return to scan interval 50 and hold limit 500
`timescale 1ns / 1ps

module button_press_hold_scanner_unit
  import bphs_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bphs_in_if.sink              in_if,
  bphs_out_if.source           out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // buttons shown in the events field
  localparam int unsigned SHOWN = (NUM_BUTTONS < PIN_COUNT) ? NUM_BUTTONS : PIN_COUNT;

  // configuration registers
  logic [CFG_W-1:0] scan_interval_q;
  logic [CFG_W-1:0] hold_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_interval_q <= SCAN_INTERVAL_RST;
      hold_limit_q    <= HOLD_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SCAN_INTERVAL: scan_interval_q <= cfg_wdata_i;
        CFG_HOLD_LIMIT:    hold_limit_q    <= cfg_wdata_i;
        default:           ;
      endcase
    end
  end

  // input register stage
  logic                 s1_valid_q;
  logic                 cmd_q;
  logic [TIME_W-1:0]    now_q;
  logic [PIN_COUNT-1:0] pins_q;
  logic [BTN_IDX_W-1:0] idx_q;

  // result register stage
  logic                out_valid_q;
  logic                clicked_q, clicked_d;
  logic                scanned_q, scanned_d;
  logic [EVENTS_W-1:0] events_q, events_d;

  logic s1_adv;
  logic in_fire;

  // the item in the input register moves on when the result register is free or drains
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_adv;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= in_if.cmd;
      now_q  <= in_if.now_ms;
      pins_q <= in_if.pin_levels;
      idx_q  <= in_if.button_index;
    end
  end

  // scan gate: modular time since the last accepted scan
  logic [TIME_W-1:0] last_scan_q;
  logic [TIME_W-1:0] since_scan;
  logic              scan_ok;

  assign since_scan = now_q - last_scan_q;
  assign scan_ok    = (cmd_q == CMD_SAMPLE) && (since_scan >= TIME_W'(scan_interval_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_scan_q <= '0;
    end else if (s1_adv && scan_ok) begin
      last_scan_q <= now_q;
    end
  end

  // state only changes when the item leaves the input register
  cell_ctrl_t ctrl;

  always_comb begin
    ctrl.scan_en    = s1_adv && scan_ok;
    ctrl.query_en   = s1_adv && (cmd_q == CMD_QUERY);
    ctrl.now_ms     = now_q;
    ctrl.hold_limit = hold_limit_q;
  end

  event_e [NUM_BUTTONS-1:0] ev_next;
  logic   [NUM_BUTTONS-1:0] click_vec;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    logic pressed;
    logic sel;

    // buttons past the pins never see a press; a query only reaches real pins
    if (i < PIN_COUNT) begin : g_pin
      assign pressed = ~pins_q[i];
      assign sel     = (idx_q == BTN_IDX_W'(i));
    end else begin : g_nopin
      assign pressed = 1'b0;
      assign sel     = 1'b0;
    end

    bphs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .pressed_i    (pressed),
      .sel_i        (sel),
      .event_next_o (ev_next[i]),
      .clicked_o    (click_vec[i])
    );
  end

  // result assembly, events reflect state after the step
  always_comb begin
    events_d = '0;
    for (int unsigned i = 0; i < SHOWN; i++) begin
      events_d[EVENT_W*i +: EVENT_W] = ev_next[i];
    end
    scanned_d = scan_ok;
    clicked_d = (cmd_q == CMD_QUERY) && (|click_vec);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_if.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      clicked_q <= clicked_d;
      scanned_q <= scanned_d;
      events_q  <= events_d;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.clicked = clicked_q;
  assign out_if.scanned = scanned_q;
  assign out_if.events  = events_q;

  // an item leaving the input register always lands in the result register
  a_adv_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("item lost between input and result register");

  // an accepted scan records its own time
  a_scan_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && scan_ok) |=> (last_scan_q == $past(now_q)))
    else $error("last scan time not updated");

  // a result is never both a scan and a click
  a_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(scanned_q && clicked_q))
    else $error("result both scanned and clicked");

  // button 0 never reports the unused event code
  a_ev_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (events_q[1:0] != 2'b11))
    else $error("illegal event code");

endmodule
